// ===== sv/adamax_pkg.sv =====
package adamax_pkg;

  localparam int unsigned ElemDepthDef = 1024;

  localparam int IdxW    = 10;
  localparam int QW      = 32;
  localparam int RegW    = 17;
  localparam int CfgIdxW = 3;
  localparam int DivNW   = 48;
  localparam int DivDW   = 32;
  localparam int DivCntW = 6;
  localparam int ProdW   = 49;
  localparam int WideW   = 52;

  localparam logic [RegW-1:0] OneQ = 17'd65536;
  localparam logic signed [QW-1:0] MaxQ = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] MinQ = 32'sh8000_0000;

  localparam logic [RegW-1:0] LrRst   = 17'd66;
  localparam logic [RegW-1:0] B1Rst   = 17'd58982;
  localparam logic [RegW-1:0] B2Rst   = 17'd65470;
  localparam logic [RegW-1:0] EpsRst  = 17'd1;
  localparam logic [RegW-1:0] WdRst   = 17'd0;

  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LR  = 3'd0,
    REG_B1  = 3'd1,
    REG_B2  = 3'd2,
    REG_EPS = 3'd3,
    REG_WD  = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_STEP, ST_BC, ST_SDIV, ST_SFIN, ST_MEM, ST_DECAY,
    ST_M1, ST_M2, ST_M3, ST_U, ST_QS, ST_QDIV, ST_QFIN, ST_UPD, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_BPOW, OP_BC, OP_SFIN, OP_MEM, OP_DECAY,
    OP_M1, OP_M2, OP_M3, OP_U, OP_QS, OP_QFIN, OP_UPD, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_busy;
    logic start;
    logic bc_zero;
    logic denom_zero;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic             ovf;
    logic signed [QW-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input wide_t v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[QW-1:0];
    if (v > wide_t'(MaxQ)) begin
      r.ovf = 1'b1;
      r.val = MaxQ;
    end else if (v < wide_t'(MinQ)) begin
      r.ovf = 1'b1;
      r.val = MinQ;
    end
    return r;
  endfunction

endpackage

// ===== sv/adamax_ctrl.sv =====
module adamax_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  adamax_pkg::status_t status,
  output adamax_pkg::cmd_t    cmd
);
  import adamax_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_STEP;
      ST_STEP:  state_nxt = status.start ? ST_BC : ST_MEM;
      ST_BC:    state_nxt = status.bc_zero ? ST_MEM : ST_SDIV;
      ST_SDIV:  if (!status.div_busy) state_nxt = ST_SFIN;
      ST_SFIN:  state_nxt = ST_MEM;
      ST_MEM:   state_nxt = ST_DECAY;
      ST_DECAY: state_nxt = ST_M1;
      ST_M1:    state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_U;
      ST_U:     state_nxt = ST_QS;
      ST_QS:    state_nxt = status.denom_zero ? ST_UPD : ST_QDIV;
      ST_QDIV:  if (!status.div_busy) state_nxt = ST_QFIN;
      ST_QFIN:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_DONE;
      ST_DONE:  if (!status.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    case (state_r)
      ST_CLEAR: cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_STEP:  if (status.start) cmd.op = OP_BPOW;
      ST_BC:    cmd.op = OP_BC;
      ST_SFIN:  cmd.op = OP_SFIN;
      ST_MEM:   cmd.op = OP_MEM;
      ST_DECAY: cmd.op = OP_DECAY;
      ST_M1:    cmd.op = OP_M1;
      ST_M2:    cmd.op = OP_M2;
      ST_M3:    cmd.op = OP_M3;
      ST_U:     cmd.op = OP_U;
      ST_QS:    cmd.op = OP_QS;
      ST_QFIN:  cmd.op = OP_QFIN;
      ST_UPD:   cmd.op = OP_UPD;
      ST_DONE:  if (!status.out_busy) cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== sv/adamax_dp.sv =====
module adamax_dp #(
  parameter int unsigned ELEMENT_DEPTH = adamax_pkg::ElemDepthDef
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  adamax_pkg::cmd_t                      cmd,
  output adamax_pkg::status_t                   status,
  input  logic                                  cfg_valid,
  input  logic [adamax_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [adamax_pkg::RegW-1:0]           cfg_data,
  input  logic [adamax_pkg::IdxW-1:0]           in_element_index,
  input  logic signed [adamax_pkg::QW-1:0]      in_param_value,
  input  logic signed [adamax_pkg::QW-1:0]      in_grad_value,
  input  logic                                  in_start_of_step,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [adamax_pkg::QW-1:0]      out_new_param_value,
  output logic                                  out_saturated
);
  import adamax_pkg::*;

  localparam int AW = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;

  // config
  logic [RegW-1:0] lr_r, b1cfg_r, b2cfg_r, eps_r, wd_r;
  logic [RegW-1:0] b1, b2, b1c;

  // item state
  logic [AW-1:0]           addr_r, addr_nxt;
  logic                    in_range_r, in_range_nxt;
  logic                    start_r, start_nxt;
  logic                    flag_r, flag_nxt;
  logic signed [QW-1:0]    p_r, p_nxt, g_r, g_nxt, m_r, m_nxt, u_r, u_nxt, q_r, q_nxt;
  logic signed [ProdW-1:0] prod_r, prod_nxt, t1_r, t1_nxt;
  logic [RegW-1:0]         bp_r, bp_nxt;
  logic [QW-1:0]           scale_r, scale_nxt;
  logic [AW-1:0]           clr_addr_r, clr_addr_nxt;

  // divider
  logic                    div_busy_r, div_busy_nxt;
  logic [DivCntW-1:0]      div_cnt_r, div_cnt_nxt;
  logic [DivDW-1:0]        div_rem_r, div_rem_nxt, div_dvs_r, div_dvs_nxt;
  logic [DivNW-1:0]        div_quo_r, div_quo_nxt;
  logic                    div_start;
  logic [DivNW-1:0]        div_dvd;
  logic [DivDW-1:0]        div_dvs;
  logic [DivDW:0]          div_shift, div_sub;
  logic                    div_ge;

  // output
  logic                    out_valid_r, out_valid_nxt, out_sat_r, out_sat_nxt;
  logic signed [QW-1:0]    out_np_r, out_np_nxt;

  // multiplier
  logic [QW-1:0]           mul_a, mul_bmag;
  logic signed [QW-1:0]    mul_bs;
  logic                    mul_en;
  logic [2*QW-1:0]         mul_full, mul_rnd;
  logic [DivNW-1:0]        mul_mag;
  logic signed [ProdW-1:0] mul_res;

  // memories
  logic signed [QW-1:0] fm_mem [ELEMENT_DEPTH];
  logic signed [QW-1:0] nm_mem [ELEMENT_DEPTH];
  logic signed [QW-1:0] fm_rd_r, nm_rd_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [RegW:0]        denom_hi;
  logic [QW:0]          denom;
  logic [RegW-1:0]      bc;
  logic [2*RegW-1:0]    bp_prod;
  logic [QW-1:0]        m_mag;

  assign b1  = (b1cfg_r > OneQ) ? OneQ : b1cfg_r;
  assign b2  = (b2cfg_r > OneQ) ? OneQ : b2cfg_r;
  assign b1c = OneQ - b1;
  assign bc  = OneQ - bp_r;
  assign bp_prod = {{RegW{1'b0}}, bp_r} * {{RegW{1'b0}}, b1} + (2*RegW)'(32768);
  assign denom = {1'b0, u_r} + (QW+1)'(eps_r);
  assign denom_hi = '0;
  assign m_mag = m_r[QW-1] ? (~m_r + 32'd1) : m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= LrRst;
      b1cfg_r <= B1Rst;
      b2cfg_r <= B2Rst;
      eps_r   <= EpsRst;
      wd_r    <= WdRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LR:  lr_r    <= cfg_data;
        REG_B1:  b1cfg_r <= cfg_data;
        REG_B2:  b2cfg_r <= cfg_data;
        REG_EPS: eps_r   <= cfg_data;
        REG_WD:  wd_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared Q16.16 multiplier, first operand always non-negative
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_bs = '0;
    case (cmd.op)
      OP_MEM: begin mul_a = QW'(wd_r); mul_bs = p_r; end
      OP_M1:  begin mul_a = QW'(b1);   mul_bs = m_r; end
      OP_M2:  begin mul_a = QW'(b1c);  mul_bs = g_r; end
      OP_M3:  begin mul_a = QW'(b2);   mul_bs = u_r; end
      OP_UPD: begin mul_a = scale_r;   mul_bs = q_r; end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_bmag = mul_bs[QW-1] ? (~mul_bs + 32'd1) : mul_bs;
  assign mul_full = mul_a * mul_bmag;
  assign mul_rnd  = mul_full + 64'd32768;
  assign mul_mag  = mul_rnd[2*QW-1:16];
  assign mul_res  = mul_bs[QW-1] ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});

  assign div_shift = {div_rem_r, div_quo_r[DivNW-1]};
  assign div_ge    = div_shift >= {1'b0, div_dvs_r};
  assign div_sub   = div_shift - {1'b0, div_dvs_r};

  always_comb begin
    sat_t s1, s2;
    s1 = '0;
    s2 = '0;
    addr_nxt      = addr_r;
    in_range_nxt  = in_range_r;
    start_nxt     = start_r;
    flag_nxt      = flag_r;
    p_nxt         = p_r;
    g_nxt         = g_r;
    m_nxt         = m_r;
    u_nxt         = u_r;
    q_nxt         = q_r;
    t1_nxt        = t1_r;
    prod_nxt      = mul_en ? mul_res : prod_r;
    bp_nxt        = bp_r;
    scale_nxt     = scale_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_np_nxt    = out_np_r;
    out_sat_nxt   = out_sat_r;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    case (cmd.op)
      OP_CLEAR: clr_addr_nxt = clr_addr_r + 1'b1;
      OP_LOAD: begin
        addr_nxt     = AW'(in_element_index);
        in_range_nxt = {22'd0, in_element_index} < 32'(ELEMENT_DEPTH);
        start_nxt    = in_start_of_step;
        flag_nxt     = 1'b0;
        p_nxt        = in_param_value;
        g_nxt        = in_grad_value;
      end
      OP_BPOW: bp_nxt = bp_prod[RegW+15:16];
      OP_BC: begin
        if (bc == '0) begin
          scale_nxt = MaxQ;
          flag_nxt  = 1'b1;
        end else begin
          div_start = 1'b1;
          div_dvd   = {15'd0, lr_r, 16'd0} + DivNW'(bc >> 1);
          div_dvs   = DivDW'(bc);
        end
      end
      OP_SFIN: begin
        if (div_quo_r > DivNW'(MaxQ)) begin
          scale_nxt = MaxQ;
          flag_nxt  = 1'b1;
        end else begin
          scale_nxt = div_quo_r[QW-1:0];
        end
      end
      OP_MEM: begin
        m_nxt = in_range_r ? fm_rd_r : '0;
        u_nxt = in_range_r ? nm_rd_r : '0;
      end
      OP_DECAY: begin
        if (wd_r != '0) begin
          s1       = sat32(wide_t'(g_r) + wide_t'(prod_r));
          g_nxt    = s1.val;
          flag_nxt = flag_r | s1.ovf;
        end
      end
      OP_M2: t1_nxt = prod_r;
      OP_M3: begin
        s1       = sat32(wide_t'(t1_r) + wide_t'(prod_r));
        m_nxt    = s1.val;
        flag_nxt = flag_r | s1.ovf;
      end
      OP_U: begin
        s1       = sat32(g_r[QW-1] ? -wide_t'(g_r) : wide_t'(g_r));
        u_nxt    = (wide_t'(prod_r) > wide_t'(s1.val)) ? prod_r[QW-1:0] : s1.val;
        flag_nxt = flag_r | s1.ovf;
      end
      OP_QS: begin
        if (denom == '0) begin
          if (m_r == '0) begin
            q_nxt = '0;
          end else begin
            q_nxt    = m_r[QW-1] ? MinQ : MaxQ;
            flag_nxt = 1'b1;
          end
        end else begin
          div_start = 1'b1;
          div_dvd   = {m_mag, 16'd0} + DivNW'(denom >> 1);
          div_dvs   = denom[DivDW-1:0];
        end
      end
      OP_QFIN: begin
        s1 = sat32(m_r[QW-1] ? -wide_t'({1'b0, div_quo_r}) : wide_t'({1'b0, div_quo_r}));
        q_nxt    = s1.val;
        flag_nxt = flag_r | s1.ovf;
      end
      OP_OUT: begin
        s1            = sat32(wide_t'(prod_r));
        s2            = sat32(wide_t'(p_r) - wide_t'(s1.val));
        out_np_nxt    = s2.val;
        out_sat_nxt   = flag_r | s1.ovf | s2.ovf;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase

    // restoring divider, one quotient bit per cycle
    div_busy_nxt = div_busy_r;
    div_cnt_nxt  = div_cnt_r;
    div_rem_nxt  = div_rem_r;
    div_quo_nxt  = div_quo_r;
    div_dvs_nxt  = div_dvs_r;
    if (div_start) begin
      div_busy_nxt = 1'b1;
      div_cnt_nxt  = '0;
      div_rem_nxt  = '0;
      div_quo_nxt  = div_dvd;
      div_dvs_nxt  = div_dvs;
    end else if (div_busy_r) begin
      div_rem_nxt = div_ge ? div_sub[DivDW-1:0] : div_shift[DivDW-1:0];
      div_quo_nxt = {div_quo_r[DivNW-2:0], div_ge};
      div_cnt_nxt = div_cnt_r + 1'b1;
      if (div_cnt_r == DivCntW'(DivNW - 1)) div_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r        <= OneQ;
      scale_r     <= '0;
      clr_addr_r  <= '0;
      div_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bp_r        <= bp_nxt;
      scale_r     <= scale_nxt;
      clr_addr_r  <= clr_addr_nxt;
      div_busy_r  <= div_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    in_range_r <= in_range_nxt;
    start_r    <= start_nxt;
    flag_r     <= flag_nxt;
    p_r        <= p_nxt;
    g_r        <= g_nxt;
    m_r        <= m_nxt;
    u_r        <= u_nxt;
    q_r        <= q_nxt;
    t1_r       <= t1_nxt;
    prod_r     <= prod_nxt;
    div_cnt_r  <= div_cnt_nxt;
    div_rem_r  <= div_rem_nxt;
    div_quo_r  <= div_quo_nxt;
    div_dvs_r  <= div_dvs_nxt;
    out_np_r   <= out_np_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign mem_we = (cmd.op == OP_CLEAR) || ((cmd.op == OP_OUT) && in_range_r);
  assign mem_wa = (cmd.op == OP_CLEAR) ? clr_addr_r : addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fm_mem[mem_wa] <= (cmd.op == OP_CLEAR) ? '0 : m_r;
      nm_mem[mem_wa] <= (cmd.op == OP_CLEAR) ? '0 : u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      fm_rd_r <= fm_mem[AW'(in_element_index)];
      nm_rd_r <= nm_mem[AW'(in_element_index)];
    end
  end

  assign status.clr_last   = clr_addr_r == AW'(ELEMENT_DEPTH - 1);
  assign status.div_busy   = div_busy_r;
  assign status.start      = start_r;
  assign status.bc_zero    = (bc == '0) && (denom_hi == '0);
  assign status.denom_zero = denom == '0;
  assign status.out_busy   = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_new_param_value = out_np_r;
  assign out_saturated       = out_sat_r;

`ifndef ASSERT_OFF
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy_r)
    else $error("divider did not start");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy_r)
    else $error("divider restarted while busy");

  a_norm_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT && in_range_r) |-> !u_r[QW-1])
    else $error("negative norm written back");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

// ===== sv/adamax_param_update.sv =====
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data (17b)
// in        in         in_valid/in_ready      element index, param, grad, start flag
// out       out        out_valid/out_ready    new param (Q16.16), saturated flag
//
// After reset the first-moment and norm memories are swept to zero, one entry
// per cycle; no request is taken during the sweep.
// One request at a time; the shared 48-step restoring divider, run for the
// step scale when start_of_step is set and for the update quotient, is the slow part.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block only stalls at writeback if it is still unread.
// Config writes are always taken (cfg_ready is tied high).
module adamax_param_update #(
  parameter int unsigned ELEMENT_DEPTH = adamax_pkg::ElemDepthDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [adamax_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [adamax_pkg::RegW-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [adamax_pkg::IdxW-1:0]      in_element_index,
  input  logic signed [adamax_pkg::QW-1:0] in_param_value,
  input  logic signed [adamax_pkg::QW-1:0] in_grad_value,
  input  logic                             in_start_of_step,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [adamax_pkg::QW-1:0] out_new_param_value,
  output logic                             out_saturated
);
  import adamax_pkg::*;

  cmd_t    cmd;
  status_t status;

  // registers are written without wait states
  assign cfg_ready = 1'b1;

  // sequencer: one step of the update per state
  adamax_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config, per-element memories, multiplier, divider, output register
  adamax_dp #(
    .ELEMENT_DEPTH (ELEMENT_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_element_index    (in_element_index),
    .in_param_value      (in_param_value),
    .in_grad_value       (in_grad_value),
    .in_start_of_step    (in_start_of_step),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_new_param_value (out_new_param_value),
    .out_saturated       (out_saturated)
  );

endmodule

// ===== tb/tb_adamax_param_update.sv =====
`timescale 1ns / 1ps

module tb_adamax_param_update;
  import adamax_pkg::*;

  localparam int Depth = 1024;
  localparam int Limit = 20000;

  // Wide holding type for intermediates; products stay below 2^63.
  typedef longint signed q64_t;

  // Behavioral Adamax predictor plus a queue of expected updated params.
  class adamax_scoreboard;
    logic [RegW-1:0] lr, b1_reg, b2_reg, eps, wd;
    int              moment[Depth];
    int              norm[Depth];
    longint unsigned bpow;
    longint unsigned scale;
    logic [QW:0]     pending[$];
    int              errors;

    function new();
      lr = LrRst; b1_reg = B1Rst; b2_reg = B2Rst; eps = EpsRst; wd = WdRst;
      foreach (moment[i]) begin
        moment[i] = 0;
        norm[i] = 0;
      end
      bpow = 65536;
      scale = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [RegW-1:0] v);
      case (r)
        REG_LR:  lr = v;
        REG_B1:  b1_reg = v;
        REG_B2:  b2_reg = v;
        REG_EPS: eps = v;
        REG_WD:  wd = v;
        default: ;
      endcase
    endfunction

    static function q64_t sat(q64_t v, ref bit f);
      if (v > 64'sd2147483647) begin
        f = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        f = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // Q16.16 product, rounded half away from zero.
    static function q64_t fmul(q64_t a, q64_t b);
      longint unsigned ma, mb, p;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = (ma * mb + 32768) >> 16;
      return ((a < 0) != (b < 0)) ? -q64_t'(p) : q64_t'(p);
    endfunction

    function void note_request(logic [IdxW-1:0] idx, logic signed [QW-1:0] pv,
                               logic signed [QW-1:0] gv, logic st);
      bit f;
      q64_t p, g, m, u, b1, b2, b2u, ag, den, q, upd, np;
      longint unsigned bc, s, qm;
      f = 0;
      p = pv;
      g = gv;
      b1 = b1_reg > OneQ ? 65536 : b1_reg;
      b2 = b2_reg > OneQ ? 65536 : b2_reg;
      if (st) begin
        bpow = (bpow * b1 + 32768) >> 16;
        bc = 65536 - bpow;
        if (bc == 0) begin
          scale = 64'h7FFF_FFFF;
          f = 1;
        end else begin
          s = ((longint'(lr) << 16) + bc / 2) / bc;
          if (s > 64'h7FFF_FFFF) begin
            s = 64'h7FFF_FFFF;
            f = 1;
          end
          scale = s;
        end
      end
      m = (idx < Depth) ? moment[idx] : 0;
      u = (idx < Depth) ? norm[idx] : 0;
      if (wd != 0) g = sat(g + fmul(wd, p), f);
      m = sat(fmul(b1, m) + fmul(65536 - b1, g), f);
      b2u = fmul(b2, u);
      ag = sat(g < 0 ? -g : g, f);
      u = b2u > ag ? b2u : ag;
      den = u + eps;
      if (den == 0) begin
        if (m == 0) q = 0;
        else begin
          q = m > 0 ? 64'sd2147483647 : -64'sd2147483648;
          f = 1;
        end
      end else begin
        qm = (((m < 0 ? -m : m) << 16) + den / 2) / den;
        q = m < 0 ? -q64_t'(qm) : q64_t'(qm);
        q = sat(q, f);
      end
      upd = sat(fmul(q64_t'(scale), q), f);
      np = sat(p - upd, f);
      if (idx < Depth) begin
        moment[idx] = int'(m);
        norm[idx] = int'(u);
      end
      pending.push_back({f, np[QW-1:0]});
    endfunction

    task check_result(logic signed [QW-1:0] np, logic sat_flag);
      logic [QW:0] e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", np));
        return;
      end
      e = pending.pop_front();
      if (np !== e[QW-1:0])
        report_mismatch($sformatf("new_param got %h want %h", np, e[QW-1:0]));
      if (sat_flag !== e[QW])
        report_mismatch($sformatf("saturated got %b want %b", sat_flag, e[QW]));
    endtask

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RegW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [IdxW-1:0] in_element_index;
  logic signed [QW-1:0] in_param_value, in_grad_value;
  logic in_start_of_step;
  logic out_valid, out_ready;
  logic signed [QW-1:0] out_new_param_value;
  logic out_saturated;

  adamax_scoreboard sb;
  int idle_pct;   // 0 during the no-idle stretch, else 21
  int quiet;      // cycles with no request or result accepted

  adamax_param_update i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: random backpressure, check on every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_new_param_value, out_saturated);
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog: the clearing sweep plus one request fits well inside Limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= Limit) begin
      $display("status: fail");
      $finish;
    end
  end

  // One config write, after which cfg_valid is lowered again.
  task automatic write_cfg(cfg_reg_t r, logic [RegW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(r, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays up after the accept; the next send or drain decides its value.
  task automatic send(logic [IdxW-1:0] idx, logic [QW-1:0] p, logic [QW-1:0] g, logic st);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_index <= idx;
    in_param_value <= p;
    in_grad_value <= g;
    in_start_of_step <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(idx, p, g, st);
  endtask

  // Wait for every expected result, then a pause before touching registers.
  task automatic drain();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (sb.pending.size() != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [QW-1:0] rand_q();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(131072);
      2: return -$urandom_range(131072);
      default: return $urandom_range(4095) - 2048;
    endcase
  endfunction

  initial begin
    sb = new();
    idle_pct = 21;
    rst_n = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_element_index = 0; in_param_value = 0; in_grad_value = 0;
    in_start_of_step = 0;
    out_ready = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no step started yet, extremes, then step starts with extreme values.
    send(10'd0, 32'h0001_0000, 32'h0000_8000, 0);
    send(10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send(10'd5, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send(10'd5, 32'h0000_0000, 32'hFFFF_0000, 0);
    send(10'd1023, 32'h1234_5678, 32'h8000_0000, 1);
    drain();
    // Beta1 of one, so the bias term stops changing; learning rate of one; epsilon zero.
    write_cfg(REG_B1, 17'd65536);
    write_cfg(REG_EPS, 17'd0);
    write_cfg(REG_LR, 17'd65536);
    send(10'd7, 32'h0002_0000, 32'h0000_0000, 1);
    send(10'd8, 32'h0002_0000, 32'h0001_0000, 0);
    send(10'd8, 32'hFFFE_0000, 32'hFFFF_0000, 0);
    drain();
    // Betas above one, weight decay of one, unknown register index ignored.
    write_cfg(REG_B1, 17'h1FFFF);
    write_cfg(REG_B2, 17'h1FFFF);
    write_cfg(REG_WD, 17'd65536);
    write_cfg(REG_EPS, 17'd65536);
    write_cfg(cfg_reg_t'(3'd7), 17'h1FFFF);
    send(10'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send(10'd9, 32'h8000_0000, 32'h8000_0000, 0);
    drain();
    write_cfg(REG_B1, 17'd0);
    write_cfg(REG_B2, 17'd0);
    write_cfg(REG_WD, 17'd0);
    write_cfg(REG_LR, 17'd0);
    send(10'd3, 32'h0000_1000, 32'h0000_2000, 1);
    send(10'd3, 32'hFFFF_F000, 32'h0000_2000, 0);
    drain();

    // Random phases: each a handful of optimizer steps over a few elements.
    for (int ph = 0; ph < 9; ph++) begin
      write_cfg(REG_LR, ph == 0 ? 17'd65536 : 17'($urandom_range(65536)));
      write_cfg(REG_B1, $urandom_range(3) == 0 ? 17'($urandom) :
                        17'(50000 + $urandom_range(15536)));
      write_cfg(REG_B2, $urandom_range(3) == 0 ? 17'($urandom) :
                        17'(60000 + $urandom_range(5536)));
      write_cfg(REG_EPS, $urandom_range(3) == 0 ? 17'($urandom_range(1)) : 17'($urandom_range(65536)));
      write_cfg(REG_WD, $urandom_range(1) ? 17'd0 : 17'($urandom_range(65536)));
      idle_pct = (ph == 4) ? 0 : 21;
      for (int st = 0; st < 5; st++) begin
        int base;
        base = $urandom_range(1015);
        for (int k = 0; k < 10; k++) begin
          logic [IdxW-1:0] idx;
          idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'(base + ($urandom_range(99) < 90 ? k % 8 : 0));
          send(idx, rand_q(), rand_q(), k == 0 || $urandom_range(19) == 0);
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
